// ===== hdl/urxf_pkg.sv =====
// ----------------------------------------------------------------------------
// urxf_pkg
// shared types and constants for the serial receive fifo with rts control
// ----------------------------------------------------------------------------
package urxf_pkg;

    // transaction codes on the input channel
    localparam logic [1:0] MODE_PUSH = 2'd0;
    localparam logic [1:0] MODE_POP  = 2'd1;
    localparam logic [1:0] MODE_POLL = 2'd2;

    // configuration register indexes
    localparam int         CFG_IDX_W        = 2;
    localparam logic [1:0] REG_PAUSE_LEVEL  = 2'd0;
    localparam logic [1:0] REG_RESUME_LEVEL = 2'd1;

    localparam int         LEVEL_W      = 9;
    localparam logic [8:0] PAUSE_RESET  = 9'd64;
    localparam logic [8:0] RESUME_RESET = 9'd128;

    typedef struct packed {
        logic [1:0] mode;
        logic [7:0] rx_byte;
    } in_item_t;

    typedef struct packed {
        logic [7:0] read_byte;
        logic       byte_valid;
        logic       data_available;
        logic       rts_out;
        logic       overflow;
        logic [8:0] free_space;
    } out_item_t;

    typedef enum logic [0:0] {
        ST_IDLE,
        ST_READ
    } state_t;

endpackage

// ===== hdl/uart_rx_fifo_rts_flow_control_core.sv =====
// ----------------------------------------------------------------------------
// uart_rx_fifo_rts_flow_control_core
// receive fifo with automatic rts hysteresis, push / pop / status transactions
// ----------------------------------------------------------------------------
// Each input transaction is a byte push, a pop or a status poll and yields
// exactly one result transaction. A push, a poll, a pop from an empty fifo
// and a dropped push load the result register directly; a pop that returns
// a byte is held in the pending register for the registered memory read and
// the input stalls in the read state. The output holds one result; a new
// transaction is taken in the same cycle the held result is taken, and the
// input stalls while that result is stalled. Pointers, free count and rts
// level update when the transaction is taken; rts rises when a push leaves
// free space below pause_level and falls when a pop leaves it above
// resume_level. A push into a full fifo is dropped and flagged. free_space
// reports the low 9 bits.
module uart_rx_fifo_rts_flow_control_core #(
    parameter int FIFO_DEPTH = 256
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  urxf_pkg::in_item_t                  in_data,
    output logic                                out_valid,
    input  logic                                out_stall,
    output urxf_pkg::out_item_t                 out_data,
    input  logic                                cfg_we,
    input  logic [urxf_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [urxf_pkg::LEVEL_W-1:0]        cfg_data
);

    localparam int PTR_W = $clog2(FIFO_DEPTH);
    localparam int CNT_W = $clog2(FIFO_DEPTH + 1);
    localparam int CMP_W = (CNT_W > urxf_pkg::LEVEL_W) ? CNT_W : urxf_pkg::LEVEL_W;
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(FIFO_DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(FIFO_DEPTH);

    logic [7:0] mem [FIFO_DEPTH];
    logic [7:0] mem_q_reg;

    urxf_pkg::state_t state_reg, state_next;

    logic [PTR_W-1:0] wptr_reg, wptr_next;
    logic [PTR_W-1:0] rptr_reg, rptr_next;
    logic [CNT_W-1:0] space_reg, space_next;
    logic             rts_reg, rts_next;
    logic [urxf_pkg::LEVEL_W-1:0] pause_reg;
    logic [urxf_pkg::LEVEL_W-1:0] resume_reg;

    urxf_pkg::out_item_t out_reg, out_next;
    urxf_pkg::out_item_t pend_reg, pend_next;
    urxf_pkg::out_item_t result;
    logic                out_valid_reg, out_valid_next;

    logic accept;
    logic is_push, is_pop;
    logic push_ok, pop_hit, push_drop;
    logic mem_we, mem_re;
    logic [CMP_W-1:0] space_after_ext;

    assign accept  = in_valid && !in_stall;
    assign is_push = (in_data.mode == urxf_pkg::MODE_PUSH);
    assign is_pop  = (in_data.mode == urxf_pkg::MODE_POP);

    assign push_ok   = is_push && (space_reg != '0);
    assign push_drop = is_push && (space_reg == '0);
    assign pop_hit   = is_pop && (space_reg != CNT_FULL);
    assign mem_we    = accept && push_ok;
    assign mem_re    = accept && pop_hit;

    // byte store, one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[wptr_reg] <= in_data.rx_byte;
        end
        if (mem_re)
        begin
            mem_q_reg <= mem[rptr_reg];
        end
    end

    // pointer, count and rts update for the current transaction
    always_comb
    begin
        wptr_next  = wptr_reg;
        rptr_next  = rptr_reg;
        space_next = space_reg;
        rts_next   = rts_reg;
        if (push_ok)
        begin
            wptr_next  = (wptr_reg == PTR_LAST) ? '0 : wptr_reg + PTR_W'(1);
            space_next = space_reg - CNT_W'(1);
        end
        else if (pop_hit)
        begin
            rptr_next  = (rptr_reg == PTR_LAST) ? '0 : rptr_reg + PTR_W'(1);
            space_next = space_reg + CNT_W'(1);
        end
        space_after_ext = CMP_W'(space_next);
        if (push_ok && !rts_reg && (space_after_ext < CMP_W'(pause_reg)))
        begin
            rts_next = 1'b1;
        end
        else if (pop_hit && rts_reg && (space_after_ext > CMP_W'(resume_reg)))
        begin
            rts_next = 1'b0;
        end
    end

    always_comb
    begin
        result.read_byte      = '0;
        result.byte_valid     = pop_hit;
        result.data_available = (space_next != CNT_FULL);
        result.rts_out        = rts_next;
        result.overflow       = push_drop;
        result.free_space     = space_after_ext[urxf_pkg::LEVEL_W-1:0];
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            urxf_pkg::ST_IDLE:
            begin
                if (accept && pop_hit)
                begin
                    state_next = urxf_pkg::ST_READ;
                end
            end
            urxf_pkg::ST_READ:
            begin
                state_next = urxf_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = urxf_pkg::ST_IDLE;
            end
        endcase
    end

    // outputs and result register loading
    always_comb
    begin
        in_stall       = 1'b0;
        out_next       = out_reg;
        pend_next      = pend_reg;
        out_valid_next = out_valid_reg && out_stall;
        case (state_reg)
            urxf_pkg::ST_IDLE:
            begin
                in_stall = out_valid_reg && out_stall;
                if (accept)
                begin
                    if (pop_hit)
                    begin
                        pend_next = result;
                    end
                    else
                    begin
                        out_next       = result;
                        out_valid_next = 1'b1;
                    end
                end
            end
            urxf_pkg::ST_READ:
            begin
                in_stall           = 1'b1;
                out_next           = pend_reg;
                out_next.read_byte = mem_q_reg;
                out_valid_next     = 1'b1;
            end
            default:
            begin
                in_stall = 1'b1;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= urxf_pkg::ST_IDLE;
            wptr_reg      <= '0;
            rptr_reg      <= '0;
            space_reg     <= CNT_FULL;
            rts_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
            pause_reg     <= urxf_pkg::PAUSE_RESET;
            resume_reg    <= urxf_pkg::RESUME_RESET;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (accept)
            begin
                wptr_reg  <= wptr_next;
                rptr_reg  <= rptr_next;
                space_reg <= space_next;
                rts_reg   <= rts_next;
            end
            if (cfg_we)
            begin
                case (cfg_index)
                    urxf_pkg::REG_PAUSE_LEVEL:  pause_reg  <= cfg_data;
                    urxf_pkg::REG_RESUME_LEVEL: resume_reg <= cfg_data;
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg  <= out_next;
        pend_reg <= pend_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule

// ===== tb/tb_uart_rx_fifo_rts_flow_control_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_uart_rx_fifo_rts_flow_control_core
// self-checking bench for the receive fifo with rts hysteresis
// ----------------------------------------------------------------------------
// A queue-fed driver offers push, pop and poll transactions. Every accepted
// transaction advances a local image of the fifo, pointers, free count and
// rts level, which yields the status the block must return. The monitor
// checks each returned status in order. Traffic runs under several
// pause/resume settings, random idling on both sides, one long receiver
// hold-off and a full fill-and-drain with dropped pushes.
module tb_uart_rx_fifo_rts_flow_control_core;

    localparam int         DEPTH        = 256;
    localparam int         QUIET_LIMIT  = 5000;
    localparam int         HOLD_CYCLES  = 300;
    localparam logic [1:0] MODE_SPARE   = 2'd3;
    localparam logic [1:0] REG_UNUSED   = 2'd3;

    logic                           clk       = 1'b0;
    logic                           rst_n     = 1'b0;
    logic                           in_valid  = 1'b0;
    logic                           in_stall;
    urxf_pkg::in_item_t             in_data   = '0;
    logic                           out_valid;
    logic                           out_stall = 1'b0;
    urxf_pkg::out_item_t            out_data;
    logic                           cfg_we    = 1'b0;
    logic [urxf_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [urxf_pkg::LEVEL_W-1:0]   cfg_data  = '0;

    uart_rx_fifo_rts_flow_control_core #(
        .FIFO_DEPTH(DEPTH)
    ) DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    // local image of the fifo
    logic [7:0]                   fifo_image [DEPTH];
    logic [7:0]                   wr_ptr      = '0;
    logic [7:0]                   rd_ptr      = '0;
    int unsigned                  space_left  = DEPTH;
    logic                         rts_lvl     = 1'b0;
    logic [urxf_pkg::LEVEL_W-1:0] pause_lvl   = urxf_pkg::PAUSE_RESET;
    logic [urxf_pkg::LEVEL_W-1:0] resume_lvl  = urxf_pkg::RESUME_RESET;

    urxf_pkg::in_item_t   rx_transactions[$];
    urxf_pkg::out_item_t  fifo_status_due[$];
    urxf_pkg::out_item_t  due_status;

    int send_idle_pct = 25;
    int recv_idle_pct = 25;
    logic hold_req    = 1'b0;
    logic hold_taken  = 1'b0;
    int hold_left     = 0;
    int errors        = 0;
    int quiet_cycles  = 0;

    int n_push = 0, n_pop = 0, n_empty_pop = 0, n_poll = 0;
    int n_overflow = 0, n_rts_edges = 0, n_settings = 0, n_full = 0;

    // advance the fifo image by one accepted transaction
    function automatic void advance_fifo_image(input urxf_pkg::in_item_t item);
        urxf_pkg::out_item_t st;
        logic                rts_was;
        st = '0;
        rts_was = rts_lvl;
        if (item.mode == urxf_pkg::MODE_PUSH)
        begin
            n_push++;
            if (space_left == 0)
            begin
                st.overflow = 1'b1;
                n_overflow++;
            end
            else
            begin
                fifo_image[wr_ptr] = item.rx_byte;
                wr_ptr++;
                space_left--;
                if (space_left == 0)
                    n_full++;
                if (!rts_lvl && space_left < pause_lvl)
                    rts_lvl = 1'b1;
            end
        end
        else if (item.mode == urxf_pkg::MODE_POP)
        begin
            n_pop++;
            if (space_left < DEPTH)
            begin
                st.read_byte  = fifo_image[rd_ptr];
                st.byte_valid = 1'b1;
                rd_ptr++;
                space_left++;
                if (rts_lvl && space_left > resume_lvl)
                    rts_lvl = 1'b0;
            end
            else
                n_empty_pop++;
        end
        else
            n_poll++;
        if (rts_lvl != rts_was)
            n_rts_edges++;
        st.data_available = (space_left < DEPTH);
        st.rts_out        = rts_lvl;
        st.free_space     = 9'(space_left);
        fifo_status_due.push_back(st);
    endfunction

    // driver: next transaction goes out once the current one is taken
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            in_data  <= '0;
        end
        else if (!in_valid || !in_stall)
        begin
            if (in_valid)
                advance_fifo_image(in_data);
            if (rx_transactions.size() != 0 && $urandom_range(99) >= send_idle_pct)
            begin
                in_valid <= 1'b1;
                in_data  <= rx_transactions.pop_front();
            end
            else
                in_valid <= 1'b0;
        end
    end

    // monitor: checks returned status and drives out_stall
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (fifo_status_due.size() == 0)
                begin
                    $display("%0t: result with nothing pending, actual %p", $time, out_data);
                    errors++;
                end
                else
                begin
                    due_status = fifo_status_due.pop_front();
                    if (out_data !== due_status)
                    begin
                        $display("%0t: status mismatch, expected %p, actual %p",
                                 $time, due_status, out_data);
                        errors++;
                    end
                end
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else if (hold_req && !hold_taken)
            begin
                hold_taken = 1'b1;
                hold_left  = HOLD_CYCLES;
                out_stall <= 1'b1;
            end
            else
                out_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    // watchdog on cycles with no transaction on either side
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("watchdog: no transaction for %0d cycles", QUIET_LIMIT);
            $display("Test completed with failures");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    task automatic queue_item(input logic [1:0] mode, input logic [7:0] data);
        urxf_pkg::in_item_t item;
        item.mode    = mode;
        item.rx_byte = data;
        rx_transactions.push_back(item);
    endtask

    // wait until the block is idle with nothing outstanding
    task automatic drain();
        while (rx_transactions.size() != 0 || in_valid || fifo_status_due.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_level(input logic [1:0] idx, input logic [8:0] val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we    <= 1'b0;
        case (idx)
            urxf_pkg::REG_PAUSE_LEVEL:  pause_lvl = val;
            urxf_pkg::REG_RESUME_LEVEL: resume_lvl = val;
            default: ;
        endcase
    endtask

    // bursts of pushes and pops with random content, plus some noise
    task automatic random_traffic(input int count);
        int left;
        int len;
        int kind;
        left = count;
        while (left > 0)
        begin
            kind = $urandom_range(9);
            len  = $urandom_range(1, 48);
            if (len > left)
                len = left;
            for (int k = 0; k < len; k++)
            begin
                if (kind < 4)
                    queue_item(urxf_pkg::MODE_PUSH, 8'($urandom_range(255)));
                else if (kind < 8)
                    queue_item(urxf_pkg::MODE_POP, 8'($urandom_range(255)));
                else
                    queue_item(2'($urandom_range(3)), 8'($urandom_range(255)));
            end
            left -= len;
        end
    endtask

    logic [8:0] pause_set  [8] = '{9'd0, 9'd511, 9'd256, 9'd100, 9'd200, 9'd0, 9'd511, 9'd255};
    logic [8:0] resume_set [8] = '{9'd0, 9'd511, 9'd0, 9'd200, 9'd100, 9'd511, 9'd0, 9'd256};

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // directed: polls, spare mode, empty pop, byte extremes, pops back out
        queue_item(urxf_pkg::MODE_POLL, 8'h00);
        queue_item(MODE_SPARE, 8'hFF);
        queue_item(urxf_pkg::MODE_POP, 8'h00);
        queue_item(urxf_pkg::MODE_PUSH, 8'h00);
        queue_item(urxf_pkg::MODE_PUSH, 8'hFF);
        queue_item(urxf_pkg::MODE_PUSH, 8'hA5);
        queue_item(urxf_pkg::MODE_PUSH, 8'h5A);
        queue_item(urxf_pkg::MODE_POLL, 8'h33);
        repeat (4) queue_item(urxf_pkg::MODE_POP, 8'hFF);
        queue_item(urxf_pkg::MODE_POP, 8'h00);
        queue_item(urxf_pkg::MODE_POLL, 8'h00);
        drain();

        // fill past full with a long receiver hold-off, then drain past empty
        send_idle_pct = 0;
        recv_idle_pct = 0;
        for (int k = 0; k < DEPTH + 3; k++)
            queue_item(urxf_pkg::MODE_PUSH, 8'($urandom_range(255)));
        @(posedge clk);
        hold_req = 1'b1;
        for (int k = 0; k < DEPTH + 3; k++)
            queue_item(urxf_pkg::MODE_POP, 8'($urandom_range(255)));
        drain();

        send_idle_pct = 25;
        recv_idle_pct = 25;
        write_level(REG_UNUSED, 9'h1FF);
        for (int s = 0; s < 8; s++)
        begin
            write_level(urxf_pkg::REG_PAUSE_LEVEL, pause_set[s]);
            write_level(urxf_pkg::REG_RESUME_LEVEL, resume_set[s]);
            n_settings++;
            if (s == 3)
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            else
            begin
                send_idle_pct = 25;
                recv_idle_pct = 25;
            end
            random_traffic(80);
            drain();
        end

        repeat (8) @(posedge clk);
        if (fifo_status_due.size() != 0)
        begin
            $display("%0t: %0d results never returned", $time, fifo_status_due.size());
            errors++;
        end
        $display("run: %0d pushes (%0d dropped, %0d times full), %0d pops (%0d on empty)",
                 n_push, n_overflow, n_full, n_pop, n_empty_pop);
        $display("run: %0d polls, %0d rts changes over %0d level settings, %0d errors",
                 n_poll, n_rts_edges, n_settings, errors);
        if (errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
